@@ rtl/core/roff_pkg.sv @@
// package for the refraction offset block
// fixed-point constants, register indexes, atan table function and shared types
package roff_pkg;

    localparam int CORDIC_STAGES_DEF = 32;
    localparam int FRAC_BITS         = 60;
    localparam int PROD_QW           = 64;
    localparam int FIN_QW            = 48;

    localparam logic signed [31:0] ELEV_LIMIT = 32'sd1686629713;
    localparam logic [63:0] ONE_THIRD = (64'd1 << 60) / 3;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [47:0] CORR_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] CORR_MIN = 48'sh8000_0000_0000;

    localparam logic [1:0] REG_COEFF_A = 2'd0;
    localparam logic [1:0] REG_COEFF_B = 2'd1;

    typedef struct packed {
        logic zero;
        logic neg;
        logic ovf;
    } t_flags;

    // unsigned q60 product, elaboration use only
    function automatic logic [63:0] roff_mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] pr;
        pr = 128'(a) * 128'(b);
        return pr[123:60];
    endfunction

    // shift-subtract quotient, elaboration use only
    function automatic logic [63:0] roff_cdiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[63:0], n[j]};
            q = {q[62:0], 1'b0};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [63:0] roff_atan_series(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        logic signed [63:0] s;
        logic signed [63:0] term;
        x2 = roff_mulq(x, x);
        p = x;
        s = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                term = signed'(roff_cdiv(p, 64'(2 * k + 1)));
                if (k[0]) s = s - term;
                else s = s + term;
                p = roff_mulq(p, x2);
            end
        end
        return s;
    endfunction

    function automatic logic signed [63:0] roff_atan(input int i);
        if (i == 0)
            return roff_atan_series(64'd1 << 59) + roff_atan_series(ONE_THIRD);
        return roff_atan_series(64'd1 << (FRAC_BITS - i));
    endfunction

    // magnitude product to signed q60, truncated toward zero and clamped
    function automatic logic signed [63:0] roff_q60(input logic [127:0] m, input logic neg);
        logic [63:0] v;
        v = (|m[127:123]) ? INT64_MAX : {1'b0, m[122:60]};
        return neg ? -signed'(v) : signed'(v);
    endfunction

endpackage

@@ rtl/core/refraction_offset.sv @@
// Refraction correction for an elevation angle. One elevation transfer is taken per cycle
// while the skid is empty, and the correction passes the input register, one CORDIC stage
// per rotation, three bit-per-stage 64-bit dividers for sin^2, cos^2 and sin*cos, a 48-stage
// final divider, pipelined 32x32 partial-product multipliers and the output register.
// A two-entry output register and skid keep input transfers flowing while a result waits.
// Users write coefficients A and B through the configuration port while the block is idle;
// the block itself does not enforce this; top level of the refraction offset block
// uses roff_pkg, roff_mul and roff_div
module refraction_offset #(
    parameter int CORDIC_STAGES = roff_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_elevation,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_correction,
    output logic               o_div_zero,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);
    import roff_pkg::*;

    localparam int LAT = CORDIC_STAGES + 128;

    logic               en;
    logic               fin;
    logic [LAT-1:0]     r_vld;
    logic [47:0]        r_coeff_a;
    logic [47:0]        r_coeff_b;
    logic signed [63:0] a_q;
    logic signed [63:0] b_q;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_a <= '0;
            r_coeff_b <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COEFF_A: r_coeff_a <= i_cfg_data;
                REG_COEFF_B: r_coeff_b <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = i_rst_n;
    assign a_q = signed'({r_coeff_a, 12'd0});
    assign b_q = signed'({r_coeff_b, 12'd0});

    // pipeline control
    logic r_s_vld;
    assign en         = ~r_s_vld;
    assign o_in_ready = en & i_rst_n;
    assign fin        = en & r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // clamp and scale
    logic signed [31:0] e_cl;
    logic signed [63:0] r_z0;
    assign e_cl = (i_elevation > ELEV_LIMIT) ? ELEV_LIMIT :
                  (i_elevation < -ELEV_LIMIT) ? -ELEV_LIMIT : i_elevation;
    always_ff @(posedge i_clk) begin
        if (en) r_z0 <= signed'({{2{e_cl[31]}}, e_cl, 30'd0});
    end

    // cordic rotation
    logic signed [63:0] r_cx [CORDIC_STAGES];
    logic signed [63:0] r_cy [CORDIC_STAGES];
    logic signed [63:0] r_cz [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        localparam logic signed [63:0] ANG = roff_atan(i);
        logic signed [63:0] xi;
        logic signed [63:0] yi;
        logic signed [63:0] zi;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        if (i == 0) begin : g_first
            assign xi = signed'(64'd1 << FRAC_BITS);
            assign yi = '0;
            assign zi = r_z0;
        end else begin : g_next
            assign xi = r_cx[i-1];
            assign yi = r_cy[i-1];
            assign zi = r_cz[i-1];
        end
        assign dx = yi >>> i;
        assign dy = xi >>> i;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!zi[63]) begin
                    r_cx[i] <= xi - dx;
                    r_cy[i] <= yi + dy;
                    r_cz[i] <= zi - ANG;
                end else begin
                    r_cx[i] <= xi + dx;
                    r_cy[i] <= yi - dy;
                    r_cz[i] <= zi + ANG;
                end
            end
        end
    end

    // squares and cross product
    logic [127:0] xx_mag;
    logic [127:0] yy_mag;
    logic [127:0] xy_mag;
    logic         xx_neg;
    logic         yy_neg;
    logic         xy_neg;

    roff_mul u_mul_xx (.i_clk, .i_en(en), .i_a(r_cx[CORDIC_STAGES-1]),
        .i_b(r_cx[CORDIC_STAGES-1]), .o_mag(xx_mag), .o_neg(xx_neg));
    roff_mul u_mul_yy (.i_clk, .i_en(en), .i_a(r_cy[CORDIC_STAGES-1]),
        .i_b(r_cy[CORDIC_STAGES-1]), .o_mag(yy_mag), .o_neg(yy_neg));
    roff_mul u_mul_xy (.i_clk, .i_en(en), .i_a(r_cx[CORDIC_STAGES-1]),
        .i_b(r_cy[CORDIC_STAGES-1]), .o_mag(xy_mag), .o_neg(xy_neg));

    logic signed [63:0] r_p;
    logic [127:0]       r_xx;
    logic [127:0]       r_yy;
    logic [127:0]       r_xy;
    logic               r_p_neg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p     <= roff_q60(xx_mag, xx_neg) + roff_q60(yy_mag, yy_neg);
            r_xx    <= xx_mag;
            r_yy    <= yy_mag;
            r_xy    <= xy_mag;
            r_p_neg <= xy_neg;
        end
    end

    // normalize by the squared gain
    logic [PROD_QW-1:0] q_s2;
    logic [PROD_QW-1:0] q_c2;
    logic [PROD_QW-1:0] q_sc;

    roff_div #(.QW(PROD_QW)) u_div_s2 (.i_clk, .i_en(en), .i_rem(r_yy[127:64]),
        .i_low(r_yy[63:0]), .i_div(64'(r_p)), .o_quo(q_s2));
    roff_div #(.QW(PROD_QW)) u_div_c2 (.i_clk, .i_en(en), .i_rem(r_xx[127:64]),
        .i_low(r_xx[63:0]), .i_div(64'(r_p)), .o_quo(q_c2));
    roff_div #(.QW(PROD_QW)) u_div_sc (.i_clk, .i_en(en), .i_rem(r_xy[127:64]),
        .i_low(r_xy[63:0]), .i_div(64'(r_p)), .o_quo(q_sc));

    logic r_neg_d [PROD_QW];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg_d[0] <= r_p_neg;
            for (int k = 1; k < PROD_QW; k++) r_neg_d[k] <= r_neg_d[k-1];
        end
    end

    logic signed [63:0] r_s2;
    logic signed [63:0] r_c2;
    logic signed [63:0] r_sc;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2 <= signed'(q_s2);
            r_c2 <= signed'(q_c2);
            r_sc <= r_neg_d[PROD_QW-1] ? -signed'(q_sc) : signed'(q_sc);
        end
    end

    // numerator and denominator terms
    logic [127:0] as2_mag;
    logic [127:0] bc2_mag;
    logic [127:0] ss_mag;
    logic         as2_neg;
    logic         bc2_neg;
    logic         ss_neg;

    roff_mul u_mul_as2 (.i_clk, .i_en(en), .i_a(a_q), .i_b(r_s2),
        .o_mag(as2_mag), .o_neg(as2_neg));
    roff_mul u_mul_bc2 (.i_clk, .i_en(en), .i_a(b_q), .i_b(r_c2),
        .o_mag(bc2_mag), .o_neg(bc2_neg));
    roff_mul u_mul_ss (.i_clk, .i_en(en), .i_a(r_s2), .i_b(r_s2),
        .o_mag(ss_mag), .o_neg(ss_neg));

    logic signed [63:0] r_as2;
    logic signed [63:0] r_bc2;
    logic signed [63:0] r_ss;
    logic signed [63:0] r_t;
    logic signed [63:0] r_den;
    logic signed [63:0] r_sc_d [5];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_as2 <= roff_q60(as2_mag, as2_neg);
            r_bc2 <= roff_q60(bc2_mag, bc2_neg);
            r_ss  <= roff_q60(ss_mag, ss_neg);
            r_t   <= r_as2 + r_bc2;
            r_den <= r_ss + r_as2 + r_bc2 + signed'({r_bc2[62:0], 1'b0});
            r_sc_d[0] <= r_sc;
            for (int k = 1; k < 5; k++) r_sc_d[k] <= r_sc_d[k-1];
        end
    end

    logic [127:0] num_mag;
    logic         num_neg;
    roff_mul u_mul_num (.i_clk, .i_en(en), .i_a(r_sc_d[4]), .i_b(r_t),
        .o_mag(num_mag), .o_neg(num_neg));

    logic signed [63:0] r_den_d [4];
    logic signed [63:0] r_num;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den_d[0] <= r_den;
            for (int k = 1; k < 4; k++) r_den_d[k] <= r_den_d[k-1];
            r_num <= roff_q60(num_mag, num_neg);
        end
    end

    // final quotient
    logic [63:0] nm;
    logic [63:0] dm;
    logic [63:0] r_nm;
    logic [63:0] r_dm;
    t_flags      r_fl;
    assign nm = r_num[63] ? 64'(-r_num) : 64'(r_num);
    assign dm = r_den_d[3][63] ? 64'(-r_den_d[3]) : 64'(r_den_d[3]);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm     <= nm;
            r_dm     <= dm;
            r_fl.zero <= (r_den_d[3] == 64'sd0);
            r_fl.neg  <= r_num[63] ^ r_den_d[3][63];
            r_fl.ovf  <= nm >= dm;
        end
    end

    logic [FIN_QW-1:0] q_fin;
    roff_div #(.QW(FIN_QW)) u_div_fin (.i_clk, .i_en(en), .i_rem(r_nm),
        .i_low('0), .i_div(r_dm), .o_quo(q_fin));

    t_flags r_fl_d [FIN_QW];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fl_d[0] <= r_fl;
            for (int k = 1; k < FIN_QW; k++) r_fl_d[k] <= r_fl_d[k-1];
        end
    end

    t_flags             fl;
    logic signed [47:0] n_corr;
    logic               n_dz;
    assign fl = r_fl_d[FIN_QW-1];
    always_comb begin
        n_dz = 1'b0;
        if (fl.zero) begin
            n_corr = '0;
            n_dz   = 1'b1;
        end else if (fl.neg) begin
            n_corr = (fl.ovf || q_fin > 48'(CORR_MIN)) ? CORR_MIN : -signed'(q_fin);
        end else begin
            n_corr = (fl.ovf || q_fin > 48'(CORR_MAX)) ? CORR_MAX : signed'(q_fin);
        end
    end

    // output register and skid
    logic               r_o_vld;
    logic signed [47:0] r_o_corr;
    logic               r_o_dz;
    logic signed [47:0] r_s_corr;
    logic               r_s_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (!r_o_vld || i_out_ready) begin
            r_o_vld <= r_s_vld | fin;
            r_s_vld <= 1'b0;
        end else if (fin) begin
            r_s_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_vld || i_out_ready) begin
            r_o_corr <= r_s_vld ? r_s_corr : n_corr;
            r_o_dz   <= r_s_vld ? r_s_dz : n_dz;
        end else if (fin) begin
            r_s_corr <= n_corr;
            r_s_dz   <= n_dz;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_correction = r_o_corr;
    assign o_div_zero   = r_o_dz;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_vld |-> r_o_vld) else $error("skid holds data with empty output");
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s_vld) |-> $past(r_o_vld && !i_out_ready))
        else $error("skid loaded without output stall");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld)) else $error("pipeline moved while stalled");
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_div_zero |-> o_correction == 48'sd0)
        else $error("zero denominator with nonzero correction");
`endif
endmodule

@@ rtl/core/roff_mul.sv @@
// pipelined 64x64 signed multiplier giving full magnitude and sign
// four 32x32 partial products, three register stages; uses roff_pkg
module roff_mul (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic [127:0]       o_mag,
    output logic               o_neg
);
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg1;
    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    logic         r_neg2;
    logic [127:0] r_mag;
    logic         r_neg3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_mb   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ll   <= 64'(r_ma[31:0]) * 64'(r_mb[31:0]);
            r_lh   <= 64'(r_ma[31:0]) * 64'(r_mb[63:32]);
            r_hl   <= 64'(r_ma[63:32]) * 64'(r_mb[31:0]);
            r_hh   <= 64'(r_ma[63:32]) * 64'(r_mb[63:32]);
            r_neg2 <= r_neg1;
            r_mag  <= {64'd0, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0}
                    + {r_hh, 64'd0};
            r_neg3 <= r_neg2;
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg3;
endmodule

@@ rtl/core/roff_div.sv @@
// pipelined restoring divider, one quotient bit per register stage
// remainder starts below the divisor; uses roff_pkg
module roff_div #(
    parameter int QW = roff_pkg::PROD_QW
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [63:0]   i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [63:0]   i_div,
    output logic [QW-1:0] o_quo
);
    logic [63:0]   r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];
    logic [63:0]   r_div [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [63:0]   rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [63:0]   div_in;
        logic [64:0]   sh;
        logic          ge;
        logic [64:0]   diff;

        if (k == 0) begin : g_first
            assign rem_in = i_rem;
            assign low_in = i_low;
            assign quo_in = '0;
            assign div_in = i_div;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign quo_in = r_quo[k-1];
            assign div_in = r_div[k-1];
        end

        assign sh   = {rem_in, low_in[QW-1]};
        assign ge   = sh >= {1'b0, div_in};
        assign diff = sh - {1'b0, div_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[63:0] : sh[63:0];
                r_low[k] <= {low_in[QW-2:0], 1'b0};
                r_quo[k] <= {quo_in[QW-2:0], ge};
                r_div[k] <= div_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
endmodule

@@ bench/refraction_offset_tb.sv @@
// testbench for refraction_offset: drives elevations and coefficient writes with random idling
// and checks every correction against a bit-exact fixed-point predictor held in a small class
// depends on roff_pkg and the refraction_offset rtl
module refraction_offset_tb;
    import roff_pkg::*;

    localparam int  STAGES    = CORDIC_STAGES_DEF;
    localparam int  LIMIT     = 600000;
    localparam int  TAIL      = 250;
    localparam int  PER_PHASE = 300;
    localparam logic signed [31:0] ELEV_MAX = ELEV_LIMIT;

    typedef struct {
        logic signed [47:0] corr;
        logic               dz;
    } t_corr;

    class correction_tracker;
        t_corr   pending_corr[$];
        longint  atan_q60[STAGES];
        longint  coeff_a_q60;
        longint  coeff_b_q60;
        int      errors;
        int      checked;
        int      zero_dens;
        int      saturated;

        function new();
            for (int i = 0; i < STAGES; i++) begin
                if (i == 0)
                    atan_q60[i] = atan_series(64'sd1 <<< 59) + atan_series((64'sd1 <<< 60) / 3);
                else
                    atan_q60[i] = atan_series(64'sd1 <<< (60 - i));
            end
            coeff_a_q60 = 0;
            coeff_b_q60 = 0;
        endfunction

        function logic [63:0] umag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint clamp_sign(logic [63:0] m, bit neg);
            if (m > INT64_MAX) m = INT64_MAX;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function logic [63:0] div_sat(logic [127:0] n, logic [63:0] d);
            logic [127:0] q;
            if (d == 0) return '1;
            q = n / {64'd0, d};
            return (|q[127:64]) ? '1 : q[63:0];
        endfunction

        function longint mul_q60(longint a, longint b);
            logic [127:0] pr;
            logic [63:0]  m;
            pr = {64'd0, umag(a)} * {64'd0, umag(b)};
            m = (|pr[127:124]) ? '1 : pr[123:60];
            return clamp_sign(m, (a < 0) != (b < 0));
        endfunction

        function longint ratio_q60(longint a, longint b, longint p);
            logic [127:0] pr;
            pr = {64'd0, umag(a)} * {64'd0, umag(b)};
            return clamp_sign(div_sat(pr, umag(p)), (a < 0) != (b < 0));
        endfunction

        function longint atan_series(longint x);
            longint x2, p, sum, term;
            x2 = mul_q60(x, x);
            p = x;
            sum = 0;
            for (int k = 0; k < 64 && p != 0; k++) begin
                term = p / longint'(2 * k + 1);
                sum = k[0] ? sum - term : sum + term;
                p = mul_q60(p, x2);
            end
            return sum;
        endfunction

        function void set_reg(logic [1:0] idx, logic [47:0] data);
            if (idx == REG_COEFF_A) coeff_a_q60 = longint'($signed(data)) * 4096;
            else if (idx == REG_COEFF_B) coeff_b_q60 = longint'($signed(data)) * 4096;
        endfunction

        function t_corr predict_correction(logic signed [31:0] elev);
            longint e, x, y, z, dx, dy, p, s2, c2, sc, t, num, den;
            logic [63:0]  q;
            logic [127:0] n;
            bit neg;
            t_corr r;
            e = elev;
            if (e > ELEV_MAX) e = ELEV_MAX;
            if (e < -longint'(ELEV_MAX)) e = -longint'(ELEV_MAX);
            z = e * 64'sd1073741824;
            x = 64'sd1 <<< 60;
            y = 0;
            for (int i = 0; i < STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_q60[i];
                end else begin
                    x += dx; y -= dy; z += atan_q60[i];
                end
            end
            p = mul_q60(x, x) + mul_q60(y, y);
            s2 = ratio_q60(y, y, p);
            c2 = ratio_q60(x, x, p);
            sc = ratio_q60(x, y, p);
            t = mul_q60(coeff_a_q60, s2) + mul_q60(coeff_b_q60, c2);
            num = mul_q60(sc, t);
            den = mul_q60(s2, s2) + mul_q60(coeff_a_q60, s2) + 3 * mul_q60(coeff_b_q60, c2);
            if (den == 0) begin
                r.corr = '0;
                r.dz = 1'b1;
                zero_dens++;
            end else begin
                n = {16'd0, umag(num), 48'd0};
                q = div_sat(n, umag(den));
                neg = (num < 0) != (den < 0);
                if (neg) begin
                    if (q > (64'd1 << 47)) begin q = 64'd1 << 47; saturated++; end
                    q = -q;
                end else if (q > (64'd1 << 47) - 1) begin
                    q = (64'd1 << 47) - 1;
                    saturated++;
                end
                r.corr = q[47:0];
                r.dz = 1'b0;
            end
            return r;
        endfunction

        function void note_elevation(logic signed [31:0] elev);
            pending_corr.push_back(predict_correction(elev));
        endfunction

        function void check_correction(logic signed [47:0] corr, logic dz);
            t_corr w;
            checked++;
            if (pending_corr.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result corr=%0d dz=%0b", corr, dz);
                return;
            end
            w = pending_corr.pop_front();
            if (w.corr !== corr || w.dz !== dz) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected corr=%0d dz=%0b, got corr=%0d dz=%0b",
                             w.corr, w.dz, corr, dz);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_elevation = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [47:0] o_correction;
    logic               o_div_zero;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [47:0]        i_cfg_data = '0;

    correction_tracker tracker = new();
    int  cycles = 0;
    int  stall_left = 0;
    int  sent = 0;
    bit  quiet = 1'b0;

    refraction_offset dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_elevation (i_elevation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_correction(o_correction),
        .o_div_zero  (o_div_zero),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // input and result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) tracker.note_elevation(i_elevation);
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_correction(o_correction, o_div_zero);
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 15) == 0)
            stall_left = $urandom_range(1, 19);
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic idle(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_elevation(logic signed [31:0] e);
        if (!quiet && $urandom_range(0, 9) == 0) idle($urandom_range(1, 19));
        i_in_valid <= 1'b1;
        i_elevation <= e;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_corr.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_coeffs(logic [47:0] a, logic [47:0] b);
        drain();
        write_reg(REG_COEFF_A, a);
        write_reg(REG_COEFF_B, b);
        write_reg(2'd2, 48'({$urandom, $urandom}));
        write_reg(2'd3, 48'({$urandom, $urandom}));
    endtask

    function automatic logic signed [31:0] rand_elevation();
        logic signed [31:0] m;
        case ($urandom_range(0, 7))
            0: m = $urandom;
            1: m = $urandom_range(0, 4096);
            2: m = ELEV_MAX - $urandom_range(0, 4096);
            default: m = $urandom_range(0, ELEV_MAX);
        endcase
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic logic [47:0] rand_coeff();
        case ($urandom_range(0, 2))
            0: return 48'({$urandom, $urandom});
            1: return 48'(64'($urandom_range(0, 32'h7fff_ffff)) * 64);
            default: return 48'(-$signed(48'($urandom_range(0, 32'h7fff_ffff)) * 64));
        endcase
    endfunction

    initial begin
        logic signed [31:0] directed[$];
        logic [47:0] a_set[6];
        logic [47:0] b_set[6];
        directed = '{32'sd0, 32'sd1, -32'sd1, ELEV_MAX, -ELEV_MAX, ELEV_MAX + 1, -ELEV_MAX - 1,
                     32'sh7fff_ffff, 32'sh8000_0000, 32'sd843314857, -32'sd843314857,
                     32'sd1000, -32'sd1000, 32'sd562209904, 32'sd1124419809,
                     32'sd1686629000, -32'sd1686629000, 32'sh5555_5555, 32'shaaaa_aaaa};
        a_set = '{48'd0, CORR_MAX, CORR_MIN, CORR_MAX, 48'(64'sd80000000000), rand_coeff()};
        b_set = '{48'd0, CORR_MAX, CORR_MIN, CORR_MIN, 48'(-64'sd90000000), rand_coeff()};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_elevation(directed[k]);
        for (int ph = 0; ph < 6; ph++) begin
            set_coeffs(a_set[ph], b_set[ph]);
            if (ph == 1 || ph == 4) foreach (directed[k]) send_elevation(directed[k]);
            if (ph == 5) quiet = 1'b1;
            for (int n = 0; n < PER_PHASE; n++) send_elevation(rand_elevation());
        end
        drain();

        $display("%0d elevations sent over 6 coefficient settings, %0d results checked",
                 sent, tracker.checked);
        $display("%0d zero denominators, %0d saturated corrections, %0d mismatches",
                 tracker.zero_dens, tracker.saturated, tracker.errors);
        if (tracker.errors == 0 && tracker.pending_corr.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
